// ===== sv/htp_pkg.sv =====
// Types, constants and arithmetic helpers for the hierarchy transform
// propagate unit. No dependencies; used by the top level.
package htp_pkg;

   localparam int unsigned ORI_W    = 16;
   localparam int unsigned POS_W    = 21;
   localparam int unsigned ROW_W    = 3 * ORI_W;
   localparam int unsigned VEC_W    = 3 * POS_W;
   localparam int unsigned FRAC_W   = 14;
   localparam int unsigned FRAME_W  = 3 * ROW_W + VEC_W;

   localparam logic [1:0] BR_PUSH = 2'd0;
   localparam logic [1:0] BR_SAME = 2'd1;
   localparam logic [1:0] BR_POP  = 2'd2;
   localparam logic [1:0] BR_HOLD = 2'd3;

   localparam logic [ORI_W-1:0] ONE_Q14 = ORI_W'(1 << FRAC_W);

   typedef struct packed {
      logic             first_node;
      logic [ROW_W-1:0] local_ori_row0;
      logic [ROW_W-1:0] local_ori_row1;
      logic [ROW_W-1:0] local_ori_row2;
      logic [VEC_W-1:0] local_position;
      logic [1:0]       branch_code;
      logic             attached_to_body;
      logic [VEC_W-1:0] attach_position;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0] abs_ori_row0;
      logic [ROW_W-1:0] abs_ori_row1;
      logic [ROW_W-1:0] abs_ori_row2;
      logic [VEC_W-1:0] abs_position;
      logic             push_dropped;
   } rsp_type;

   typedef struct packed {
      logic [ROW_W-1:0] ori_row0;
      logic [ROW_W-1:0] ori_row1;
      logic [ROW_W-1:0] ori_row2;
      logic [VEC_W-1:0] position;
   } frame_type;

   localparam frame_type ROOT_FRAME = '{
      ori_row0: {{(2*ORI_W){1'b0}}, ONE_Q14},
      ori_row1: {{ORI_W{1'b0}}, ONE_Q14, {ORI_W{1'b0}}},
      ori_row2: {ONE_Q14, {(2*ORI_W){1'b0}}},
      position: '0
   };

   // One orientation entry: parent row dotted with a local column,
   // rounded half up to Q2.14 and saturated.
   function automatic logic [ORI_W-1:0] ori_dot(input logic [ROW_W-1:0] prow,
                                                input logic [ORI_W-1:0] l0,
                                                input logic [ORI_W-1:0] l1,
                                                input logic [ORI_W-1:0] l2);
      logic signed [31:0] m0, m1, m2;
      logic signed [34:0] acc;
      logic signed [20:0] sh;
      logic [ORI_W-1:0]   res;
      m0  = signed'(prow[15:0])  * signed'(l0);
      m1  = signed'(prow[31:16]) * signed'(l1);
      m2  = signed'(prow[47:32]) * signed'(l2);
      acc = 35'(m0) + 35'(m1) + 35'(m2) + 35'sd8192;
      sh  = 21'(acc >>> FRAC_W);
      if (sh > 21'sd32767) begin
         res = 16'h7FFF;
      end else if (sh < -21'sd32768) begin
         res = 16'h8000;
      end else begin
         res = sh[15:0];
      end
      return res;
   endfunction

   // One position coordinate: parent coordinate plus parent row dotted with
   // the local position, rounded half up to Q13.8 and saturated.
   function automatic logic [POS_W-1:0] pos_dot(input logic [ROW_W-1:0] prow,
                                                input logic [POS_W-1:0] pp,
                                                input logic [VEC_W-1:0] lp);
      logic signed [36:0] m0, m1, m2;
      logic signed [39:0] acc;
      logic signed [25:0] sh;
      logic [POS_W-1:0]   res;
      m0  = signed'(prow[15:0])  * signed'(lp[20:0]);
      m1  = signed'(prow[31:16]) * signed'(lp[41:21]);
      m2  = signed'(prow[47:32]) * signed'(lp[62:42]);
      acc = (40'(signed'(pp)) <<< FRAC_W) + 40'(m0) + 40'(m1) + 40'(m2)
            + 40'sd8192;
      sh  = 26'(acc >>> FRAC_W);
      if (sh > 26'sd1048575) begin
         res = 21'h0FFFFF;
      end else if (sh < -26'sd1048576) begin
         res = 21'h100000;
      end else begin
         res = sh[20:0];
      end
      return res;
   endfunction

endpackage

// ===== sv/htp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module htp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/hierarchy_transform_propagate_unit.sv =====
// Hierarchy transform propagate unit: forward kinematics over a node stream.
// Depends on htp_pkg and htp_ram.
//
// Usage:
//  - req_ channel carries one skeleton node per item in depth-first order;
//    rsp_ channel returns its absolute orientation, absolute position and
//    the push_dropped flag, one result item per node, in order.
//  - Both channels use valid/stall; an item moves when valid is high and
//    stall is low.
//  - An item accepted into the input register is computed there and lands in
//    the result register, where rsp_valid rises. Throughput is one node per
//    cycle while rsp_stall is low, as the 3x3 product against the parent
//    frame held in registers is combinational.
//  - The parent frame at stack top lives in registers; frames below it sit in
//    a STACK_DEPTH-entry RAM whose registered read is kept pointed at the
//    entry just under the top, so a pop needs no wait for a RAM read.
//  - When rsp_stall is high the result register holds and one more node can
//    wait in the input register; after that req_stall rises.
//  - Reset empties both registers, sets the stack to the identity root and
//    needs no clearing pass. first_node restarts the stack at the root.
module hierarchy_transform_propagate_unit #(
   parameter int unsigned STACK_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  htp_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output htp_pkg::rsp_type rsp_item
);

   localparam int unsigned AW = $clog2(STACK_DEPTH);

   logic               in_valid_ff, in_valid_in;
   htp_pkg::req_type   in_item_ff;
   logic               out_valid_ff, out_valid_in;
   htp_pkg::rsp_type   out_item_ff, out_item_in;
   logic [AW-1:0]      top_ff, top_in;
   htp_pkg::frame_type top_frame_ff, top_frame_in;
   logic               byp_ff, byp_in;
   htp_pkg::frame_type byp_frame_ff, byp_frame_in;

   logic               advance;
   logic               accept;
   logic [AW-1:0]      cur_top;
   htp_pkg::frame_type cur_frame;
   htp_pkg::frame_type parent;
   htp_pkg::frame_type below;
   htp_pkg::frame_type result;
   htp_pkg::frame_type ram_q;
   logic               do_push, do_pop, full;
   logic               wr_en;
   logic [AW-1:0]      rd_addr;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign cur_top   = in_item_ff.first_node ? '0 : top_ff;
   assign cur_frame = in_item_ff.first_node ? htp_pkg::ROOT_FRAME : top_frame_ff;
   assign full      = (cur_top == AW'(STACK_DEPTH - 1));
   assign do_push   = advance && (in_item_ff.branch_code == htp_pkg::BR_PUSH) && !full;
   assign do_pop    = advance && (in_item_ff.branch_code == htp_pkg::BR_POP)
                      && (cur_top != '0);
   assign below     = byp_ff ? byp_frame_ff : ram_q;

   always_comb begin
      if (in_item_ff.attached_to_body) begin
         parent          = htp_pkg::ROOT_FRAME;
         parent.position = in_item_ff.attach_position;
      end else begin
         parent = cur_frame;
      end
   end

   // One column of the local orientation per result entry
   always_comb begin
      logic [htp_pkg::ROW_W-1:0] prow [3];
      logic [htp_pkg::ROW_W-1:0] orow [3];
      prow[0] = parent.ori_row0;
      prow[1] = parent.ori_row1;
      prow[2] = parent.ori_row2;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            orow[r][c*htp_pkg::ORI_W +: htp_pkg::ORI_W] = htp_pkg::ori_dot(prow[r],
               in_item_ff.local_ori_row0[c*htp_pkg::ORI_W +: htp_pkg::ORI_W],
               in_item_ff.local_ori_row1[c*htp_pkg::ORI_W +: htp_pkg::ORI_W],
               in_item_ff.local_ori_row2[c*htp_pkg::ORI_W +: htp_pkg::ORI_W]);
         end
         result.position[r*htp_pkg::POS_W +: htp_pkg::POS_W] = htp_pkg::pos_dot(prow[r],
            parent.position[r*htp_pkg::POS_W +: htp_pkg::POS_W],
            in_item_ff.local_position);
      end
      result.ori_row0 = orow[0];
      result.ori_row1 = orow[1];
      result.ori_row2 = orow[2];
   end

   always_comb begin
      out_item_in.abs_ori_row0 = result.ori_row0;
      out_item_in.abs_ori_row1 = result.ori_row1;
      out_item_in.abs_ori_row2 = result.ori_row2;
      out_item_in.abs_position = result.position;
      out_item_in.push_dropped = (in_item_ff.branch_code == htp_pkg::BR_PUSH) && full;
   end

   // Stack update; keep the RAM read aimed just below the new top
   always_comb begin
      top_in       = top_ff;
      top_frame_in = top_frame_ff;
      byp_in       = 1'b0;
      byp_frame_in = byp_frame_ff;
      wr_en        = 1'b0;
      if (advance) begin
         top_in       = cur_top;
         top_frame_in = cur_frame;
         if (do_push) begin
            top_in       = cur_top + AW'(1);
            top_frame_in = result;
            wr_en        = 1'b1;
            byp_in       = 1'b1;
            byp_frame_in = cur_frame;
         end else if (do_pop) begin
            top_in       = cur_top - AW'(1);
            top_frame_in = below;
         end
      end
      rd_addr = top_in - AW'(1);
   end

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         top_ff       <= '0;
         top_frame_ff <= htp_pkg::ROOT_FRAME;
         byp_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         top_ff       <= top_in;
         top_frame_ff <= top_frame_in;
         byp_ff       <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
      byp_frame_ff <= byp_frame_in;
   end

   htp_ram #(
      .WIDTH (htp_pkg::FRAME_W),
      .DEPTH (STACK_DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cur_top),
      .wr_data (cur_frame),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

`ifndef SYNTHESIS
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with no item held");

   a_bypass_above_root: assert property (@(posedge clock) disable iff (reset)
      byp_ff |-> (top_ff != '0))
      else $error("bypass frame live at stack root");

   a_push_moves_top: assert property (@(posedge clock) disable iff (reset)
      do_push |=> (top_ff == $past(cur_top) + AW'(1)))
      else $error("push did not advance stack top");

   a_result_follows_item: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed item produced no result");
`endif

endmodule
